// File: rtl/core/crse_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the Catmull-Rom spline evaluator.
// No dependencies; crse_store, crse_basis, crse_dot, the top level and crse_checker import it.

package crse_pkg;

    // Action codes carried by an input beat.
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POS    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GRAD   = 2'd2;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int PARAM_W   = 22;
    localparam int FRAC_BITS = 16;
    localparam int SEG_W     = PARAM_W - FRAC_BITS;
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

    localparam int MAX_POINTS_DEF = 64;

    // Four control points feed every evaluation.
    localparam int PTS = 4;

    // Datapath widths. Every basis weight stays below 2^(FRAC_BITS+4) in magnitude.
    localparam int WGT_W  = FRAC_BITS + 5;
    localparam int PROD_W = COORD_W + WGT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int A_W    = ACC_W - FRAC_BITS;
    localparam int SCL_W  = A_W + GAIN_W + 1;
    localparam int RND_W  = SCL_W - GAIN_FRAC;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // Per-stage load enables of the evaluation pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } stage_ld_t;

endpackage

// File: rtl/core/crse_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module crse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/crse_store.sv
`timescale 1ns / 1ps
// Control point store: point count, four interleaved RAM banks, segment range check
// and the pipeline registers that line up the four points. Uses crse_pkg, crse_ram.

module crse_store import crse_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             append,
    input  point_t           wr_pt,
    input  logic [SEG_W-1:0] seg,
    input  stage_ld_t        ld,
    output logic             seg_err,
    output point_t           pts [PTS]
);

    localparam int BANKS  = 4;
    localparam int BSEL_W = 2;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int BANK_D = (MAX_POINTS + BANKS - 1) / BANKS;
    localparam int ROW_W  = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int CMP_W  = ((SEG_W > CNT_W) ? SEG_W : CNT_W) + 1;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              wr_ok;
    logic [ROW_W-1:0]  wr_row;
    logic [SEG_W-1:0]  base;
    logic [ROW_W-1:0]  rd_row [BANKS];
    point_t            bank_q [BANKS];
    logic [BSEL_W-1:0] rot_reg;
    point_t            pt2_reg [PTS];
    point_t            pt2_next [PTS];
    point_t            pt3_reg [PTS];

    // Point n lives in bank n mod 4, row n / 4, so any four consecutive points
    // sit in four different banks and are read in the same cycle.
    assign wr_ok      = append && (count_reg < CNT_W'(MAX_POINTS));
    assign count_next = wr_ok ? count_reg + CNT_W'(1) : count_reg;
    assign wr_row     = ROW_W'(count_reg >> BSEL_W);

    assign seg_err = (seg == '0) || ((CMP_W'(seg) + CMP_W'(2)) >= CMP_W'(count_reg));

    // First point of the window is seg - 1.
    assign base = seg - SEG_W'(1);

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [SEG_W-1:0] row_full;

        assign row_full  = (base >> BSEL_W) + SEG_W'(BSEL_W'(b) < base[BSEL_W-1:0]);
        assign rd_row[b] = ROW_W'(row_full);

        crse_ram #(
            .WIDTH ($bits(point_t)),
            .DEPTH (BANK_D)
        ) u_ram (
            .clk   (clk),
            .we    (wr_ok && (count_reg[BSEL_W-1:0] == BSEL_W'(b))),
            .waddr (wr_row),
            .wdata (wr_pt),
            .re    (ld.s1),
            .raddr (rd_row[b]),
            .rdata (bank_q[b])
        );
    end

    always_comb
    begin
        for (int k = 0; k < PTS; k++)
        begin
            pt2_next[k] = bank_q[BSEL_W'(rot_reg + BSEL_W'(k))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            rot_reg <= base[BSEL_W-1:0];
        end
        if (ld.s2)
        begin
            pt2_reg <= pt2_next;
        end
        if (ld.s3)
        begin
            pt3_reg <= pt2_reg;
        end
    end

    assign pts = pt3_reg;

endmodule

// File: rtl/core/crse_basis.sv
`timescale 1ns / 1ps
// Basis weight pipeline: t^2, t^3 and the four position or gradient weights.
// Uses crse_pkg.

module crse_basis import crse_pkg::*; (
    input  logic                     clk,
    input  stage_ld_t                ld,
    input  logic [FRAC_BITS-1:0]     frac,
    input  logic                     grad,
    output logic signed [WGT_W-1:0]  wgt [PTS]
);

    localparam int SQ_W = 2 * FRAC_BITS;
    localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(1 << FRAC_BITS);

    logic [FRAC_BITS-1:0] f1_reg;
    logic [FRAC_BITS-1:0] tt1_reg;
    logic                 grad1_reg;
    logic [FRAC_BITS-1:0] f2_reg;
    logic [FRAC_BITS-1:0] tt2_reg;
    logic [FRAC_BITS-1:0] ttt2_reg;
    logic                 grad2_reg;
    logic [SQ_W-1:0]      sq;
    logic [SQ_W-1:0]      cube;
    logic signed [WGT_W-1:0] fs;
    logic signed [WGT_W-1:0] t2;
    logic signed [WGT_W-1:0] t3;
    logic signed [WGT_W-1:0] w_next [PTS];
    logic signed [WGT_W-1:0] w_reg [PTS];

    assign sq   = SQ_W'(frac) * SQ_W'(frac);
    assign cube = SQ_W'(tt1_reg) * SQ_W'(f1_reg);

    assign fs = $signed(WGT_W'(f2_reg));
    assign t2 = $signed(WGT_W'(tt2_reg));
    assign t3 = $signed(WGT_W'(ttt2_reg));

    always_comb
    begin
        if (grad2_reg)
        begin
            w_next[0] = (fs <<< 2) - (t2 <<< 1) - t2 - ONE_W;
            w_next[1] = (t2 <<< 3) + t2 - (fs <<< 3) - (fs <<< 1);
            w_next[2] = (fs <<< 3) + ONE_W - (t2 <<< 3) - t2;
            w_next[3] = (t2 <<< 1) + t2 - (fs <<< 1);
        end
        else
        begin
            w_next[0] = (t2 <<< 1) - t3 - fs;
            w_next[1] = (t3 <<< 1) + t3 - (t2 <<< 2) - t2 + (ONE_W <<< 1);
            w_next[2] = (t2 <<< 2) + fs - (t3 <<< 1) - t3;
            w_next[3] = t3 - t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            f1_reg    <= frac;
            tt1_reg   <= sq[SQ_W-1:FRAC_BITS];
            grad1_reg <= grad;
        end
        if (ld.s2)
        begin
            f2_reg    <= f1_reg;
            tt2_reg   <= tt1_reg;
            ttt2_reg  <= cube[SQ_W-1:FRAC_BITS];
            grad2_reg <= grad1_reg;
        end
        if (ld.s3)
        begin
            w_reg <= w_next;
        end
    end

    assign wgt = w_reg;

endmodule

// File: rtl/core/crse_dot.sv
`timescale 1ns / 1ps
// One axis of the spline sum: four products, rounding, tension scaling and
// saturation to 32 bits. Uses crse_pkg.

module crse_dot import crse_pkg::*; (
    input  logic                      clk,
    input  stage_ld_t                 ld,
    input  logic signed [COORD_W-1:0] pts [PTS],
    input  logic signed [WGT_W-1:0]   wgt [PTS],
    input  logic [GAIN_W-1:0]         gain,
    output logic signed [COORD_W-1:0] res
);

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SCL_W-1:0] SCL_HALF = SCL_W'(1 << (GAIN_FRAC - 1));

    logic signed [PROD_W-1:0] prod_reg [PTS];
    logic signed [PROD_W-1:0] prod_next [PTS];
    logic signed [ACC_W-1:0]  acc;
    logic signed [A_W-1:0]    avg_reg;
    logic signed [A_W-1:0]    avg_next;
    logic signed [SCL_W-1:0]  scl_reg;
    logic signed [SCL_W-1:0]  scl_next;
    logic signed [SCL_W-1:0]  scl_rnd;
    logic signed [RND_W-1:0]  rnd;

    always_comb
    begin
        for (int k = 0; k < PTS; k++)
        begin
            prod_next[k] = PROD_W'(pts[k]) * PROD_W'(wgt[k]);
        end
    end

    // Round half up and drop the fraction; the arithmetic shift floors.
    assign acc = ACC_HALF + ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])
               + ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);
    assign avg_next = $signed(acc[ACC_W-1:FRAC_BITS]);

    assign scl_next = SCL_W'(avg_reg) * $signed(SCL_W'(gain));
    assign scl_rnd  = scl_reg + SCL_HALF;
    assign rnd      = $signed(scl_rnd[SCL_W-1:GAIN_FRAC]);

    always_comb
    begin
        if (&rnd[RND_W-1:COORD_W-1] || ~|rnd[RND_W-1:COORD_W-1])
        begin
            res = rnd[COORD_W-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            res = {1'b1, {(COORD_W - 1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s4)
        begin
            prod_reg <= prod_next;
        end
        if (ld.s5)
        begin
            avg_reg <= avg_next;
        end
        if (ld.s6)
        begin
            scl_reg <= scl_next;
        end
    end

endmodule

// File: rtl/core/catmull_rom_spline_eval_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Beat contents
// in       in   in_valid / in_ready    action, coord_x, coord_y, coord_z, curve_param
// out      out  out_valid / out_ready  res_x, res_y, res_z, range_error
// cfg      in   cfg_we (never waits)   cfg_wdata -> tension_gain
//
// Throughput is one input beat per cycle while any stage has room or out_ready is
// high. The evaluation path is a seven-stage pipeline; an evaluate beat raises
// out_valid once it has moved through the stages to the last. Four control points are
// needed per evaluation; the store is split into four interleaved banks, one read
// port each, so every window of four consecutive points is fetched in the same cycle.
// Append beats write the store at the accepting edge and produce no output beat;
// an evaluate beat right after an append already sees the new point.
// rst_n clears the point count, the tension gain (to 0.5) and all stage valid bits.
// Each stage holds while its successor is full and stalled, so bubbles are
// squeezed out and in_ready stays high while any stage has room.
//
// Top level of the Catmull-Rom spline evaluator. Depends on crse_pkg, crse_store,
// crse_basis and crse_dot.

module catmull_rom_spline_eval_top import crse_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [PARAM_W-1:0]        curve_param,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] res_x,
    output logic signed [COORD_W-1:0] res_y,
    output logic signed [COORD_W-1:0] res_z,
    output logic                      range_error,
    input  logic                      cfg_we,
    input  logic [GAIN_W-1:0]         cfg_wdata
);

    localparam int NSTG = 7;

    logic [NSTG:1]   valid_reg;
    logic [NSTG:1]   valid_next;
    logic [NSTG:1]   err_reg;
    logic [NSTG:1]   err_next;
    logic [NSTG+1:1] rdy;
    stage_ld_t       ld;
    logic            accept;
    logic            is_eval;
    logic            seg_err;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    point_t          wr_pt;
    point_t          pts [PTS];
    logic signed [COORD_W-1:0] px [PTS];
    logic signed [COORD_W-1:0] py [PTS];
    logic signed [COORD_W-1:0] pz [PTS];
    logic signed [WGT_W-1:0]   wgt [PTS];
    logic signed [COORD_W-1:0] sat_x;
    logic signed [COORD_W-1:0] sat_y;
    logic signed [COORD_W-1:0] sat_z;
    logic signed [COORD_W-1:0] res_x_reg;
    logic signed [COORD_W-1:0] res_y_reg;
    logic signed [COORD_W-1:0] res_z_reg;
    logic signed [COORD_W-1:0] res_x_next;
    logic signed [COORD_W-1:0] res_y_next;
    logic signed [COORD_W-1:0] res_z_next;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        rdy[NSTG + 1] = out_ready;
        for (int k = NSTG; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
    end

    assign ld.s1 = rdy[1];
    assign ld.s2 = rdy[2];
    assign ld.s3 = rdy[3];
    assign ld.s4 = rdy[4];
    assign ld.s5 = rdy[5];
    assign ld.s6 = rdy[6];
    assign ld.s7 = rdy[7];

    assign in_ready = rdy[1];
    assign accept   = in_valid && in_ready;
    assign is_eval  = action inside {ACT_POS, ACT_GRAD};

    // Only evaluate beats enter the pipeline; appends and the spare code leave
    // a bubble behind them.
    always_comb
    begin
        valid_next = valid_reg;
        err_next   = err_reg;
        if (rdy[1])
        begin
            valid_next[1] = accept && is_eval;
            err_next[1]   = seg_err;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k - 1];
                err_next[k]   = err_reg[k - 1];
            end
        end
    end

    assign gain_next = cfg_we ? cfg_wdata : gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            gain_reg  <= GAIN_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            gain_reg  <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
    end

    assign wr_pt.x = coord_x;
    assign wr_pt.y = coord_y;
    assign wr_pt.z = coord_z;

    crse_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .append  (accept && (action == ACT_APPEND)),
        .wr_pt   (wr_pt),
        .seg     (curve_param[PARAM_W-1:FRAC_BITS]),
        .ld      (ld),
        .seg_err (seg_err),
        .pts     (pts)
    );

    crse_basis u_basis (
        .clk  (clk),
        .ld   (ld),
        .frac (curve_param[FRAC_BITS-1:0]),
        .grad (action == ACT_GRAD),
        .wgt  (wgt)
    );

    always_comb
    begin
        for (int k = 0; k < PTS; k++)
        begin
            px[k] = pts[k].x;
            py[k] = pts[k].y;
            pz[k] = pts[k].z;
        end
    end

    crse_dot u_dot_x (
        .clk  (clk),
        .ld   (ld),
        .pts  (px),
        .wgt  (wgt),
        .gain (gain_reg),
        .res  (sat_x)
    );

    crse_dot u_dot_y (
        .clk  (clk),
        .ld   (ld),
        .pts  (py),
        .wgt  (wgt),
        .gain (gain_reg),
        .res  (sat_y)
    );

    crse_dot u_dot_z (
        .clk  (clk),
        .ld   (ld),
        .pts  (pz),
        .wgt  (wgt),
        .gain (gain_reg),
        .res  (sat_z)
    );

    // Out-of-range segments report zero coordinates.
    assign res_x_next = err_reg[NSTG - 1] ? '0 : sat_x;
    assign res_y_next = err_reg[NSTG - 1] ? '0 : sat_y;
    assign res_z_next = err_reg[NSTG - 1] ? '0 : sat_z;

    always_ff @(posedge clk)
    begin
        if (ld.s7)
        begin
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
            res_z_reg <= res_z_next;
        end
    end

    assign out_valid   = valid_reg[NSTG];
    assign res_x       = res_x_reg;
    assign res_y       = res_y_reg;
    assign res_z       = res_z_reg;
    assign range_error = err_reg[NSTG];

endmodule

// File: rtl/core/crse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the spline evaluator, bound to the top level.
// Uses crse_pkg.

module crse_checker import crse_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [ACT_W-1:0]          action,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] res_x,
    input logic signed [COORD_W-1:0] res_y,
    input logic signed [COORD_W-1:0] res_z,
    input logic                      range_error
);

    // A free output side means no stage can be blocked.
    a_ready_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready
    ) else $error("in_ready low while out_ready high");

    // An evaluate beat with out_ready held high along the way raises out_valid.
    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (action == ACT_POS || action == ACT_GRAD))
        ##1 out_ready ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid
    ) else $error("evaluate beat did not reach the output in time");

    // A range error carries zero coordinates.
    a_err_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (res_x == '0 && res_y == '0 && res_z == '0)
    ) else $error("range error with nonzero coordinates");

    // A stalled output beat holds.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_x) && $stable(res_y)
                                       && $stable(res_z) && $stable(range_error))
    ) else $error("stalled output beat changed");

endmodule

bind catmull_rom_spline_eval_top crse_checker u_checker (.*);

// File: verif/tb_catmull_rom_spline_eval_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for catmull_rom_spline_eval_top: a point-store and
// spline predictor in a small scoreboard class, and handshake tasks that drive it.
// Depends on crse_pkg and the RTL under rtl/core.

import crse_pkg::*;

// Tracks the control-point store and the tension gain as the block sees them,
// and keeps the queue of curve samples that evaluate beats are due to produce.
class spline_tracker;
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      err;
    } sample_t;

    sample_t           curve_samples[$];
    longint            pts[3][MAX_POINTS_DEF];
    int                point_total;
    logic [GAIN_W-1:0] gain;
    int                failures;

    function new();
        point_total = 0;
        gain = GAIN_RESET;
        failures = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] value);
        gain = value;
    endfunction

    // Rounds the Q23.8 x Q.16 sum back to Q23.8, applies the gain and saturates.
    function logic signed [COORD_W-1:0] scale_axis(longint acc);
        longint a;
        longint r;
        a = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r = (a * longint'(gain) + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[COORD_W-1:0];
    endfunction

    function void note_beat(logic [ACT_W-1:0] act, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                            logic [PARAM_W-1:0] prm);
        sample_t s;
        longint  f;
        longint  tt;
        longint  ttt;
        longint  unit;
        longint  w[PTS];
        longint  acc[3];
        int      seg;
        if (act == ACT_APPEND) begin
            // A full store silently drops the point.
            if (point_total < MAX_POINTS_DEF) begin
                pts[0][point_total] = longint'(x);
                pts[1][point_total] = longint'(y);
                pts[2][point_total] = longint'(z);
                point_total++;
            end
            return;
        end
        if (act != ACT_POS && act != ACT_GRAD)
            return;
        seg = int'(prm[PARAM_W-1:FRAC_BITS]);
        f = longint'(prm[FRAC_BITS-1:0]);
        if (seg < 1 || seg + 2 >= point_total) begin
            s.x = '0;
            s.y = '0;
            s.z = '0;
            s.err = 1'b1;
            curve_samples.push_back(s);
            return;
        end
        unit = longint'(1) <<< FRAC_BITS;
        tt = (f * f) >>> FRAC_BITS;
        ttt = (tt * f) >>> FRAC_BITS;
        if (act == ACT_POS) begin
            w[0] = -ttt + 2 * tt - f;
            w[1] = 3 * ttt - 5 * tt + 2 * unit;
            w[2] = -3 * ttt + 4 * tt + f;
            w[3] = ttt - tt;
        end else begin
            w[0] = -3 * tt + 4 * f - unit;
            w[1] = 9 * tt - 10 * f;
            w[2] = -9 * tt + 8 * f + unit;
            w[3] = 3 * tt - 2 * f;
        end
        for (int a = 0; a < 3; a++) begin
            acc[a] = 0;
            for (int k = 0; k < PTS; k++)
                acc[a] += pts[a][seg - 1 + k] * w[k];
        end
        s.x = scale_axis(acc[0]);
        s.y = scale_axis(acc[1]);
        s.z = scale_axis(acc[2]);
        s.err = 1'b0;
        curve_samples.push_back(s);
    endfunction

    function void check_sample(logic signed [COORD_W-1:0] rx, logic signed [COORD_W-1:0] ry,
                               logic signed [COORD_W-1:0] rz, logic rerr);
        sample_t s;
        if (curve_samples.size() == 0) begin
            $error("result beat with no evaluation outstanding: x=%0d y=%0d z=%0d err=%0b",
                   rx, ry, rz, rerr);
            failures++;
            return;
        end
        s = curve_samples.pop_front();
        if (rx !== s.x) begin
            $error("res_x: expected %0d, got %0d", s.x, rx);
            failures++;
        end
        if (ry !== s.y) begin
            $error("res_y: expected %0d, got %0d", s.y, ry);
            failures++;
        end
        if (rz !== s.z) begin
            $error("res_z: expected %0d, got %0d", s.z, rz);
            failures++;
        end
        if (rerr !== s.err) begin
            $error("range_error: expected %0b, got %0b", s.err, rerr);
            failures++;
        end
    endfunction
endclass

module tb_catmull_rom_spline_eval_top;

    // Action code 3 is unused by the block; it must be swallowed without effect.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // The receiver holds off this long once, so the seven-stage pipeline fills
    // and in_ready has to drop.
    localparam int HOLD_CYCLES = 80;
    // Quiet cycles after the last result, enough to cover the pipeline depth.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 5;
    localparam int PHASE_BEATS = 100;
    // Watchdog, in ns; roughly forty times the slowest legal run.
    localparam int LIMIT_NS = 2_000_000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [ACT_W-1:0]          action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PARAM_W-1:0]        curve_param;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] res_x;
    logic signed [COORD_W-1:0] res_y;
    logic signed [COORD_W-1:0] res_z;
    logic                      range_error;
    logic                      cfg_we;
    logic [GAIN_W-1:0]         cfg_wdata;

    // Upper bounds of the per-beat idle draws on each side, changed per phase.
    int gap_max;
    int stall_max;
    // Set by the stimulus process to ask the result sink for one long hold-off.
    bit hold_off;

    spline_tracker tracker = new();

    catmull_rom_spline_eval_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .curve_param (curve_param),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_z       (res_z),
        .range_error (range_error),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Coordinates are mostly full-range random words, with the extremes and
    // small signed values mixed in so that both saturation and exact sums occur.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            4, 5: return {{20{rnd[11]}}, rnd[11:0]};
            default: return rnd;
        endcase
    endfunction

    // Most evaluations land on a usable segment of the points stored so far;
    // the rest take any parameter at all and mostly fall out of range.
    function automatic logic [PARAM_W-1:0] pick_param(int stored);
        logic [31:0]          rnd;
        logic [SEG_W-1:0]     seg;
        logic [FRAC_BITS-1:0] frac;
        rnd = $urandom;
        if (stored < 4 || $urandom_range(0, 9) >= 8)
            return rnd[PARAM_W-1:0];
        seg = rnd[SEG_W-1:0];
        seg = SEG_W'($urandom_range(1, stored - 3));
        case ($urandom_range(0, 7))
            0: frac = '0;
            1: frac = '1;
            default: frac = rnd[31:32-FRAC_BITS];
        endcase
        return {seg, frac};
    endfunction

    // Offers one input beat, starting and ending at a falling edge. The idle
    // gap is drawn first; valid then stays high until the beat is taken.
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z,
                             input logic [PARAM_W-1:0] prm);
        int n;
        n = $urandom_range(0, gap_max);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        curve_param <= prm;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_beat(act, x, y, z, prm);
        @(negedge clk);
    endtask

    // Stops offering beats and waits until every expected sample has come back,
    // then lets the pipeline run empty of appends and ignored beats as well.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.curve_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The gain register is only written while the block is idle.
    task automatic write_gain(input logic [GAIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tracker.set_gain(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result sink. For every beat it draws a stall, then holds out_ready high
    // until a beat is taken and checks it against the oldest expected sample.
    initial
    begin : result_sink
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            tracker.check_sample(res_x, res_y, res_z, range_error);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus: a directed opening at the reset gain, then five random phases,
    // each behind a full drain and a gain write, with different idling patterns.
    initial
    begin : stimulus
        int                  done;
        int                  r;
        int                  append_pct;
        logic [31:0]         rnd;
        logic [GAIN_W-1:0]   g;
        logic [ACT_W-1:0]    act;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_APPEND;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        curve_param = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        gap_max     = 0;
        stall_max   = 0;
        hold_off    = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Evaluations against an empty store must all come back out of range.
        send_beat(ACT_POS, '0, '0, '0, 22'h01_0000);
        send_beat(ACT_GRAD, '0, '0, '0, 22'h3F_FFFF);
        send_beat(ACT_SPARE, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 22'h3F_FFFF);
        // Four points, mostly at the coordinate extremes, make the first usable segment.
        send_beat(ACT_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
        send_beat(ACT_APPEND, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0);
        send_beat(ACT_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 22'h3F_FFFF);
        send_beat(ACT_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, '0);
        // Segment one at both ends of the fraction and at the midpoint.
        send_beat(ACT_POS, '0, '0, '0, 22'h01_0000);
        send_beat(ACT_POS, '0, '0, '0, 22'h01_FFFF);
        send_beat(ACT_GRAD, '0, '0, '0, 22'h01_0000);
        send_beat(ACT_GRAD, '0, '0, '0, 22'h01_FFFF);
        send_beat(ACT_POS, '0, '0, '0, 22'h01_8000);
        // Segment zero has no predecessor; segment two lacks a successor yet.
        send_beat(ACT_POS, '0, '0, '0, 22'h00_1234);
        send_beat(ACT_GRAD, '0, '0, '0, 22'h02_4000);
        // One more point opens segment two, and the evaluation right behind the
        // append must already see it.
        send_beat(ACT_APPEND, 32'sd1, -32'sd1, 32'sd256, '0);
        send_beat(ACT_GRAD, '0, '0, '0, 22'h02_4000);
        send_beat(ACT_POS, '0, '0, '0, 22'h02_FFFF);
        send_beat(ACT_POS, '0, '0, '0, 22'h03_0000);
        send_beat(ACT_SPARE, rand_coord(), rand_coord(), rand_coord(), 22'h02_8000);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            rnd = $urandom;
            case (ph)
                0: begin g = 17'd65536;     gap_max = 7; stall_max = 7; end
                1: begin g = 17'h1_FFFF;    gap_max = 0; stall_max = 0; end
                2: begin g = 17'd0;         gap_max = 7; stall_max = 0; end
                3: begin g = rnd[GAIN_W-1:0]; gap_max = 0; stall_max = 7; end
                default: begin g = 17'd1;   gap_max = 7; stall_max = 7; end
            endcase
            write_gain(g);
            // The phase without idling also carries the long receiver hold-off,
            // so the sender keeps pushing into a pipeline that cannot drain.
            if (ph == 1)
                hold_off = 1'b1;

            done = 0;
            while (done < PHASE_BEATS)
            begin
                r = $urandom_range(0, 99);
                // Appends come thick while the store is nearly empty; once it is
                // full they keep coming and must all be dropped.
                append_pct = (tracker.point_total < 8) ? 40 : 14;
                if (r < 4)
                begin
                    rnd = $urandom;
                    send_beat(ACT_SPARE, rand_coord(), rand_coord(), rand_coord(),
                              rnd[PARAM_W-1:0]);
                end
                else
                begin
                    if (r < 4 + append_pct)
                        act = ACT_APPEND;
                    else if (r[0])
                        act = ACT_POS;
                    else
                        act = ACT_GRAD;
                    send_beat(act, rand_coord(), rand_coord(), rand_coord(),
                              pick_param(tracker.point_total));
                    done++;
                end
            end
            wait_idle();
        end

        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
